FILE: design/tagged_halo_width_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tagged halo width table
// Shared property wrappers. They expect signals named clk and arst_n in the
// scope where they are used.
// ----------------------------------------------------------------------------
`ifndef TAGGED_HALO_WIDTH_TABLE_CORE_ASSERT_SVH
`define TAGGED_HALO_WIDTH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define THWT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define THWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/thwt_pkg.sv
// ----------------------------------------------------------------------------
// thwt_pkg
// Constants, codes and types shared by the tagged halo width table files.
// ----------------------------------------------------------------------------
package thwt_pkg;

	localparam int ENTRIES  = 256;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int KEY_W    = 48;
	localparam int TAG_BITS = 48;
	localparam int WIDTH_W  = 16;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	localparam logic signed [WIDTH_W-1:0] WIDTH_MAX = {1'b0, {(WIDTH_W-1){1'b1}}};
	localparam logic signed [WIDTH_W-1:0] NO_WIDTH  = {WIDTH_W{1'b1}};

	// Action codes; the unused code behaves like a get.
	localparam logic [ACT_W-1:0] ACT_GET = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SET = 2'd1;
	localparam logic [ACT_W-1:0] ACT_INC = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

	typedef struct packed {
		logic [TAG_BITS-1:0]       tag;
		logic signed [WIDTH_W-1:0] wx;
		logic signed [WIDTH_W-1:0] wy;
		logic signed [WIDTH_W-1:0] wz;
	} entry_t;

	// Add a delta to a stored width and clamp the sum to 0..WIDTH_MAX.
	function automatic logic signed [WIDTH_W-1:0] clamp_add(
		input logic signed [WIDTH_W-1:0] base,
		input logic signed [WIDTH_W-1:0] delta
	);
		logic signed [WIDTH_W:0] sum;
		logic signed [WIDTH_W-1:0] res;
		sum = {base[WIDTH_W-1], base} + {delta[WIDTH_W-1], delta};
		if (sum[WIDTH_W]) begin
			res = '0;
		end else if (sum > {1'b0, WIDTH_MAX}) begin
			res = WIDTH_MAX;
		end else begin
			res = sum[WIDTH_W-1:0];
		end
		return res;
	endfunction

endpackage

FILE: design/thwt_if.sv
// ----------------------------------------------------------------------------
// thwt channel interfaces
// Valid/ready channels for the request and result items of the table.
// ----------------------------------------------------------------------------
interface thwt_req_if;
	logic                                       valid;
	logic                                       ready;
	logic [thwt_pkg::ACT_W-1:0]                 action;
	logic [thwt_pkg::KEY_W-1:0]                 key;
	logic signed [thwt_pkg::WIDTH_W-1:0]        halo_x;
	logic signed [thwt_pkg::WIDTH_W-1:0]        halo_y;
	logic signed [thwt_pkg::WIDTH_W-1:0]        halo_z;

	modport source (output valid, action, key, halo_x, halo_y, halo_z, input ready);
	modport sink   (input valid, action, key, halo_x, halo_y, halo_z, output ready);
endinterface

interface thwt_rsp_if;
	logic                                       valid;
	logic                                       ready;
	logic [thwt_pkg::STAT_W-1:0]                status;
	logic signed [thwt_pkg::WIDTH_W-1:0]        width_x;
	logic signed [thwt_pkg::WIDTH_W-1:0]        width_y;
	logic signed [thwt_pkg::WIDTH_W-1:0]        width_z;

	modport source (output valid, status, width_x, width_y, width_z, input ready);
	modport sink   (input valid, status, width_x, width_y, width_z, output ready);
endinterface

FILE: design/tagged_halo_width_table_core.sv
// ----------------------------------------------------------------------------
// tagged_halo_width_table_core
// Associative table of key tags, each holding three signed halo widths.
// ----------------------------------------------------------------------------
// Usage: each item on the req channel is one action (get, set or invalidate,
// increment) on the key given. Exactly one item leaves on the rsp channel for
// every request: a status and the three widths held after the action, or -1
// for all three widths when no valid entry holds the key afterwards.
// The block works on one request at a time. After a request is taken, the
// entry memory and the valid bits are read one entry per cycle from entry 0
// upward; the scan stops at the first matching valid entry and otherwise runs
// over the whole table, noting the lowest free entry on the way. The ST_EXEC
// state then applies the action and loads the result register. The scan
// goes one entry at a time because the entry memory has a single read port.
// The next request can be taken from the cycle after the result register is
// loaded. The result register separates the two sides: a new request is
// taken while an earlier result still waits. If the receiver stalls, the
// finished action waits before writing the table until the result register
// is free.
// Reset clears all valid bits at once; the tag and width memory needs no
// clearing, since only entries marked valid are ever used.
// ----------------------------------------------------------------------------
module tagged_halo_width_table_core (
	input  logic          clk,
	input  logic          arst_n,
	thwt_req_if.sink      req,
	thwt_rsp_if.source    rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;

	// Latched request.
	logic [thwt_pkg::ACT_W-1:0]          act_q;
	logic [thwt_pkg::TAG_BITS-1:0]       key_q;
	logic signed [thwt_pkg::WIDTH_W-1:0] hx_q;
	logic signed [thwt_pkg::WIDTH_W-1:0] hy_q;
	logic signed [thwt_pkg::WIDTH_W-1:0] hz_q;

	// Entry memory: tag and widths, one synchronous read port.
	thwt_pkg::entry_t ent_mem_q [thwt_pkg::ENTRIES];
	thwt_pkg::entry_t mem_rdata_q;
	thwt_pkg::entry_t mem_wdata;
	logic [thwt_pkg::IDX_W-1:0] mem_waddr;
	logic mem_we;

	logic [thwt_pkg::ENTRIES-1:0] valid_q;
	// Valid bit of the entry read alongside mem_rdata_q.
	logic                         vld_rdata_q;

	// Scan control: issue side and the compare stage in the cycle after it.
	logic [thwt_pkg::IDX_W-1:0] issue_idx_q;
	logic                       issue_on_q;
	logic [thwt_pkg::IDX_W-1:0] idx_s1;
	logic                       chk_s1;

	logic                       hit_q;
	logic [thwt_pkg::IDX_W-1:0] hit_idx_q;
	thwt_pkg::entry_t           hit_ent_q;
	logic                       free_hit_q;
	logic [thwt_pkg::IDX_W-1:0] free_idx_q;

	// Result register.
	logic                                out_valid_q;
	logic [thwt_pkg::STAT_W-1:0]         out_status_q;
	logic signed [thwt_pkg::WIDTH_W-1:0] out_wx_q;
	logic signed [thwt_pkg::WIDTH_W-1:0] out_wy_q;
	logic signed [thwt_pkg::WIDTH_W-1:0] out_wz_q;

	logic take;
	logic fire;
	logic scan_hit;
	logic inval;
	logic vld_set;
	logic vld_clr;
	logic [thwt_pkg::STAT_W-1:0]         res_status;
	logic signed [thwt_pkg::WIDTH_W-1:0] res_wx;
	logic signed [thwt_pkg::WIDTH_W-1:0] res_wy;
	logic signed [thwt_pkg::WIDTH_W-1:0] res_wz;

	assign req.ready   = (state_q == ST_IDLE);
	assign take        = req.valid && req.ready;
	assign fire        = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.width_x = out_wx_q;
	assign rsp.width_y = out_wy_q;
	assign rsp.width_z = out_wz_q;

	assign scan_hit = chk_s1 && vld_rdata_q && (mem_rdata_q.tag == key_q);
	assign inval    = hx_q[thwt_pkg::WIDTH_W-1] || hy_q[thwt_pkg::WIDTH_W-1] ||
		hz_q[thwt_pkg::WIDTH_W-1];

	// Decide the outcome of the action once the scan is over.
	always_comb begin
		res_status = thwt_pkg::STAT_OK;
		res_wx     = thwt_pkg::NO_WIDTH;
		res_wy     = thwt_pkg::NO_WIDTH;
		res_wz     = thwt_pkg::NO_WIDTH;
		mem_we     = 1'b0;
		mem_waddr  = hit_idx_q;
		mem_wdata  = '{tag: key_q, wx: hx_q, wy: hy_q, wz: hz_q};
		vld_set    = 1'b0;
		vld_clr    = 1'b0;
		case (act_q)
			thwt_pkg::ACT_SET: begin
				if (hit_q) begin
					if (inval) begin
						vld_clr = 1'b1;
					end else begin
						mem_we = 1'b1;
						res_wx = hx_q;
						res_wy = hy_q;
						res_wz = hz_q;
					end
				end else if (!inval) begin
					if (free_hit_q) begin
						mem_we    = 1'b1;
						mem_waddr = free_idx_q;
						vld_set   = 1'b1;
						res_wx    = hx_q;
						res_wy    = hy_q;
						res_wz    = hz_q;
					end else begin
						res_status = thwt_pkg::STAT_FULL;
					end
				end
			end
			thwt_pkg::ACT_INC: begin
				if (hit_q) begin
					res_wx    = thwt_pkg::clamp_add(hit_ent_q.wx, hx_q);
					res_wy    = thwt_pkg::clamp_add(hit_ent_q.wy, hy_q);
					res_wz    = thwt_pkg::clamp_add(hit_ent_q.wz, hz_q);
					mem_we    = 1'b1;
					mem_wdata = '{tag: key_q, wx: res_wx, wy: res_wy, wz: res_wz};
				end else begin
					res_status = thwt_pkg::STAT_NOT_FOUND;
				end
			end
			default: begin
				if (hit_q) begin
					res_wx = hit_ent_q.wx;
					res_wy = hit_ent_q.wy;
					res_wz = hit_ent_q.wz;
				end else begin
					res_status = thwt_pkg::STAT_NOT_FOUND;
				end
			end
		endcase
	end

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (fire && mem_we) begin
			ent_mem_q[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= ent_mem_q[issue_idx_q];
		vld_rdata_q <= valid_q[issue_idx_q];
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire) begin
			if (vld_clr) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (vld_set) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// Sequencer and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_idx_q <= '0;
			issue_on_q  <= 1'b0;
			idx_s1      <= '0;
			chk_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_hit_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q     <= ST_SCAN;
						issue_idx_q <= '0;
						issue_on_q  <= 1'b1;
						chk_s1      <= 1'b0;
						hit_q       <= 1'b0;
						free_hit_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					chk_s1 <= issue_on_q;
					idx_s1 <= issue_idx_q;
					if (issue_on_q) begin
						if (issue_idx_q == thwt_pkg::IDX_LAST) begin
							issue_on_q <= 1'b0;
						end else begin
							issue_idx_q <= issue_idx_q + 1'b1;
						end
					end
					if (chk_s1) begin
						if (!vld_rdata_q && !free_hit_q) begin
							free_hit_q <= 1'b1;
						end
						if (scan_hit) begin
							hit_q      <= 1'b1;
							issue_on_q <= 1'b0;
							chk_s1     <= 1'b0;
							state_q    <= ST_EXEC;
						end else if (idx_s1 == thwt_pkg::IDX_LAST) begin
							chk_s1  <= 1'b0;
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= req.action;
			key_q <= req.key[thwt_pkg::TAG_BITS-1:0];
			hx_q  <= req.halo_x;
			hy_q  <= req.halo_y;
			hz_q  <= req.halo_z;
		end
		if ((state_q == ST_SCAN) && chk_s1) begin
			if (!vld_rdata_q && !free_hit_q) begin
				free_idx_q <= idx_s1;
			end
			if (scan_hit) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= mem_rdata_q;
			end
		end
		if (fire) begin
			out_status_q <= res_status;
			out_wx_q     <= res_wx;
			out_wy_q     <= res_wy;
			out_wz_q     <= res_wz;
		end
	end

endmodule

FILE: design/thwt_checker.sv
// ----------------------------------------------------------------------------
// thwt_checker
// Port-level checks on the tagged halo width table, bound to the top level.
// ----------------------------------------------------------------------------
`include "tagged_halo_width_table_core_assert.svh"

module thwt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [thwt_pkg::STAT_W-1:0]         rsp_status,
	input logic signed [thwt_pkg::WIDTH_W-1:0] rsp_width_x,
	input logic signed [thwt_pkg::WIDTH_W-1:0] rsp_width_y,
	input logic signed [thwt_pkg::WIDTH_W-1:0] rsp_width_z
);

	logic no_widths;
	logic all_nonneg;
	logic rsp_stall;
	logic rsp_ok;
	logic status_known;
	logic [thwt_pkg::STAT_W+3*thwt_pkg::WIDTH_W-1:0] rsp_data;

	assign no_widths = (rsp_width_x == thwt_pkg::NO_WIDTH) &&
		(rsp_width_y == thwt_pkg::NO_WIDTH) && (rsp_width_z == thwt_pkg::NO_WIDTH);
	assign all_nonneg = !rsp_width_x[thwt_pkg::WIDTH_W-1] &&
		!rsp_width_y[thwt_pkg::WIDTH_W-1] && !rsp_width_z[thwt_pkg::WIDTH_W-1];
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_ok    = (rsp_status == thwt_pkg::STAT_OK);
	assign status_known = rsp_ok || (rsp_status == thwt_pkg::STAT_NOT_FOUND) ||
		(rsp_status == thwt_pkg::STAT_FULL);
	assign rsp_data  = {rsp_status, rsp_width_x, rsp_width_y, rsp_width_z};

	// A stalled result holds.
	`THWT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

	// One request at a time: the table is busy right after taking one.
	`THWT_ASSERT_NEXT(a_one_busy, req_valid && req_ready, !req_ready, "request taken while busy")

	`THWT_ASSERT_SAME(a_status_code, rsp_valid, status_known, "undefined status code")

	// Failures never report widths.
	`THWT_ASSERT_SAME(a_fail_widths, rsp_valid && !rsp_ok, no_widths, "failure returned widths")

	// Stored widths are never negative; success shows either them or none.
	`THWT_ASSERT_SAME(a_ok_widths, rsp_valid && rsp_ok, no_widths || all_nonneg, "bad success widths")

endmodule

bind tagged_halo_width_table_core thwt_checker u_thwt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_width_x (rsp.width_x),
	.rsp_width_y (rsp.width_y),
	.rsp_width_z (rsp.width_z)
);

FILE: dv/tagged_halo_width_table_core_test.sv
// ----------------------------------------------------------------------------
// tagged_halo_width_table_core_test
// Self-checking bench for the tagged halo width table. A directed table walks
// the corner cases of get, set, invalidate and increment. Random traffic then
// works a small set of hot keys, fills the table until it reports full, and
// punches holes into it again. Results not given in a directed row are
// compared with a shadow copy of the table kept in the bench.
// ----------------------------------------------------------------------------
module tagged_halo_width_table_core_test;

	import thwt_pkg::*;

	// The spare action code acts like a get.
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 700;
	localparam int DIR_ROWS     = 24;
	// A miss scans the whole table, so the tail covers a full scan.
	localparam int DRAIN_CYCLES = ENTRIES + 40;

	localparam logic [KEY_W-1:0] KEY_ZERO  = '0;
	localparam logic [KEY_W-1:0] KEY_ONES  = '1;
	localparam logic [KEY_W-1:0] KEY_TOP   = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_GHOST = 48'h5A5A_A5A5_0F0F;

	localparam logic signed [WIDTH_W-1:0] W_MIN = {1'b1, {(WIDTH_W-1){1'b0}}};

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [KEY_W-1:0]   key;
		logic [WIDTH_W-1:0] hx;
		logic [WIDTH_W-1:0] hy;
		logic [WIDTH_W-1:0] hz;
	} halo_request_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [WIDTH_W-1:0] wx;
		logic [WIDTH_W-1:0] wy;
		logic [WIDTH_W-1:0] wz;
	} halo_result_t;

	typedef struct packed {
		halo_request_t stim;
		bit            typed;
		halo_result_t  want;
	} directed_row_t;

	localparam halo_result_t NOT_HELD = '{STAT_NOT_FOUND, NO_WIDTH, NO_WIDTH, NO_WIDTH};
	localparam halo_result_t DROPPED  = '{STAT_OK, NO_WIDTH, NO_WIDTH, NO_WIDTH};

	// Directed stimulus. Where typed is set the expected result is written in
	// the row; the other rows are checked against the shadow table.
	directed_row_t directed_rows [DIR_ROWS] = '{
		// Right after reset nothing is held, key zero included.
		'{'{ACT_GET, KEY_ZERO, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NOT_HELD},
		'{'{ACT_INC, KEY_ZERO, 16'sd1, 16'sd1, 16'sd1}, 1'b1, NOT_HELD},
		'{'{ACT_SET, KEY_ZERO, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
			'{STAT_OK, 16'sd0, 16'sd0, 16'sd0}},
		'{'{ACT_GET, KEY_ZERO, 16'sd9, 16'sd9, 16'sd9}, 1'b1,
			'{STAT_OK, 16'sd0, 16'sd0, 16'sd0}},
		// Differs from key zero in the top bit only.
		'{'{ACT_GET, KEY_TOP, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NOT_HELD},
		'{'{ACT_SET, KEY_ONES, WIDTH_MAX, WIDTH_MAX, WIDTH_MAX}, 1'b1,
			'{STAT_OK, WIDTH_MAX, WIDTH_MAX, WIDTH_MAX}},
		// Saturation at the top of the range.
		'{'{ACT_INC, KEY_ONES, WIDTH_MAX, WIDTH_MAX, WIDTH_MAX}, 1'b1,
			'{STAT_OK, WIDTH_MAX, WIDTH_MAX, WIDTH_MAX}},
		// Clamping at zero with negative deltas, two of them the most negative.
		'{'{ACT_INC, KEY_ZERO, W_MIN, NO_WIDTH, W_MIN}, 1'b1,
			'{STAT_OK, 16'sd0, 16'sd0, 16'sd0}},
		'{'{ACT_INC, KEY_ZERO, WIDTH_MAX, 16'sd1, 16'sd100}, 1'b1,
			'{STAT_OK, WIDTH_MAX, 16'sd1, 16'sd100}},
		// The spare code reads like a get and ignores the widths.
		'{'{ACT_SPARE, KEY_ONES, NO_WIDTH, NO_WIDTH, NO_WIDTH}, 1'b1,
			'{STAT_OK, WIDTH_MAX, WIDTH_MAX, WIDTH_MAX}},
		'{'{ACT_SET, KEY_TOP, 16'sd100, 16'sd200, 16'sd300}, 1'b1,
			'{STAT_OK, 16'sd100, 16'sd200, 16'sd300}},
		'{'{ACT_INC, KEY_TOP, -16'sd150, WIDTH_MAX, -16'sd300}, 1'b1,
			'{STAT_OK, 16'sd0, WIDTH_MAX, 16'sd0}},
		'{'{ACT_SET, KEY_TOP, 16'sd1, 16'sd2, 16'sd3}, 1'b1,
			'{STAT_OK, 16'sd1, 16'sd2, 16'sd3}},
		'{'{ACT_GET, KEY_TOP, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
		// A set that hits with one negative width drops the entry.
		'{'{ACT_SET, KEY_TOP, 16'sd5, 16'sd0, NO_WIDTH}, 1'b1, DROPPED},
		'{'{ACT_GET, KEY_TOP, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NOT_HELD},
		// A set that misses with a negative width changes nothing.
		'{'{ACT_SET, KEY_GHOST, W_MIN, 16'sd0, 16'sd0}, 1'b1, DROPPED},
		'{'{ACT_GET, KEY_GHOST, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NOT_HELD},
		// Reuses the hole left by the dropped entry.
		'{'{ACT_SET, KEY_TOP, 16'sd7, 16'sd8, 16'sd9}, 1'b1,
			'{STAT_OK, 16'sd7, 16'sd8, 16'sd9}},
		'{'{ACT_INC, KEY_ONES, W_MIN, W_MIN, W_MIN}, 1'b1,
			'{STAT_OK, 16'sd0, 16'sd0, 16'sd0}},
		'{'{ACT_GET, KEY_ZERO, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{ACT_SPARE, KEY_GHOST, 16'sd1, 16'sd1, 16'sd1}, 1'b1, NOT_HELD},
		'{'{ACT_SET, KEY_ZERO, 16'sd0, 16'sd0, W_MIN}, 1'b1, DROPPED},
		'{'{ACT_GET, KEY_ONES, 16'sh1234, -16'sd7, 16'sd0}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	thwt_req_if req_ch ();
	thwt_rsp_if rsp_ch ();

	tagged_halo_width_table_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the table. Tags and widths are only read in valid
	// entries, so their initial contents do not matter.
	bit                  mirror_valid [ENTRIES];
	logic [TAG_BITS-1:0] mirror_tag   [ENTRIES];
	logic [WIDTH_W-1:0]  mirror_wx    [ENTRIES];
	logic [WIDTH_W-1:0]  mirror_wy    [ENTRIES];
	logic [WIDTH_W-1:0]  mirror_wz    [ENTRIES];

	halo_result_t        pending_widths [$];
	logic [KEY_W-1:0]    hot_keys [$];
	logic [KEY_W-1:0]    seen_keys [$];
	int                  mismatches;
	int                  items_sent;
	int                  results_seen;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tagged_halo_width_table_core_test: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	function automatic logic [WIDTH_W-1:0] clamp_sum(input logic [WIDTH_W-1:0] base,
		input logic [WIDTH_W-1:0] delta);
		int sum;
		sum = int'($signed(base)) + int'($signed(delta));
		if (sum < 0) begin
			return '0;
		end else if (sum > int'(WIDTH_MAX)) begin
			return WIDTH_MAX;
		end
		return sum[WIDTH_W-1:0];
	endfunction

	// Applies one action to the shadow table and returns the result the
	// block owes for it. The match and the lowest free entry are taken from
	// the table as it stood before the action.
	function automatic halo_result_t table_apply(input halo_request_t it);
		logic [TAG_BITS-1:0] tag;
		int                  hit;
		int                  slot;
		bit                  drop;
		halo_result_t        res;
		tag  = it.key[TAG_BITS-1:0];
		hit  = -1;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && mirror_valid[i] && mirror_tag[i] == tag) hit = i;
			if (slot < 0 && !mirror_valid[i]) slot = i;
		end
		drop = it.hx[WIDTH_W-1] | it.hy[WIDTH_W-1] | it.hz[WIDTH_W-1];
		res  = DROPPED;
		if (it.action == ACT_SET) begin
			if (hit >= 0 && drop) begin
				mirror_valid[hit] = 1'b0;
			end else if (hit >= 0 || (!drop && slot >= 0)) begin
				if (hit < 0) begin
					hit               = slot;
					mirror_valid[hit] = 1'b1;
					mirror_tag[hit]   = tag;
				end
				mirror_wx[hit] = it.hx;
				mirror_wy[hit] = it.hy;
				mirror_wz[hit] = it.hz;
				res = '{STAT_OK, it.hx, it.hy, it.hz};
			end else if (!drop) begin
				res.status = STAT_FULL;
			end
		end else if (hit < 0) begin
			res = NOT_HELD;
		end else begin
			if (it.action == ACT_INC) begin
				mirror_wx[hit] = clamp_sum(mirror_wx[hit], it.hx);
				mirror_wy[hit] = clamp_sum(mirror_wy[hit], it.hy);
				mirror_wz[hit] = clamp_sum(mirror_wz[hit], it.hz);
			end
			res = '{STAT_OK, mirror_wx[hit], mirror_wy[hit], mirror_wz[hit]};
		end
		return res;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		return KEY_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [KEY_W-1:0] any_seen_key();
		return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
	endfunction

	// Widths lean toward the ends of the range now and then, so that sets
	// store extremes and increments clamp in both directions.
	function automatic logic [WIDTH_W-1:0] draw_width(input bit non_negative);
		int pick;
		pick = $urandom_range(0, 9);
		if (non_negative) begin
			case (pick)
				0: return '0;
				1: return WIDTH_MAX;
				default: return WIDTH_W'($urandom_range(0, int'(WIDTH_MAX)));
			endcase
		end
		case (pick)
			0: return W_MIN;
			1: return NO_WIDTH;
			2: return WIDTH_MAX;
			3: return '0;
			default: return WIDTH_W'($urandom());
		endcase
	endfunction

	// Presents one item and returns once it has been taken. Valid is only
	// lowered when a gap follows, so back-to-back items keep it high.
	task automatic send_item(input halo_request_t it);
		int gap;
		gap = ((items_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= it.action;
		req_ch.key    <= it.key;
		req_ch.halo_x <= it.hx;
		req_ch.halo_y <= it.hy;
		req_ch.halo_z <= it.hz;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Result side: stalls at random and checks each taken item against the
	// oldest expectation.
	initial begin : result_sink
		halo_result_t got;
		halo_result_t want;
		int           gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ((results_seen / 37) % 3 == 2) ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got = '{rsp_ch.status, rsp_ch.width_x, rsp_ch.width_y, rsp_ch.width_z};
			if (pending_widths.size() == 0) begin
				report_mismatch("result arrived with nothing pending");
			end else begin
				want = pending_widths.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.wx !== want.wx)
					report_mismatch($sformatf("width_x %0d, expected %0d",
						$signed(got.wx), $signed(want.wx)));
				if (got.wy !== want.wy)
					report_mismatch($sformatf("width_y %0d, expected %0d",
						$signed(got.wy), $signed(want.wy)));
				if (got.wz !== want.wz)
					report_mismatch($sformatf("width_z %0d, expected %0d",
						$signed(got.wz), $signed(want.wz)));
			end
			results_seen++;
		end
	end

	initial begin : request_source
		halo_request_t it;
		halo_result_t  want;
		int            pick;
		mismatches    = 0;
		items_sent    = 0;
		results_seen  = 0;
		arst_n        <= 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.action <= ACT_GET;
		req_ch.key    <= '0;
		req_ch.halo_x <= '0;
		req_ch.halo_y <= '0;
		req_ch.halo_z <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases. The shadow table follows every row so that
		// the random part starts from the right contents.
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(directed_rows[r].stim);
			want = table_apply(directed_rows[r].stim);
			if (directed_rows[r].typed) want = directed_rows[r].want;
			pending_widths.push_back(want);
		end

		hot_keys = '{KEY_ZERO, KEY_ONES, KEY_TOP, KEY_GHOST};
		repeat (8) hot_keys.push_back(fresh_key());
		seen_keys = hot_keys;

		// Random traffic in three stretches. First a dozen hot keys take every
		// kind of action so that hits, updates and clamping are frequent.
		// Then mostly sets on fresh keys run the table into the full state.
		// Last, existing entries are dropped and the holes refilled, which
		// also brings the table back to full now and then.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			it.hx = draw_width(1'b0);
			it.hy = draw_width(1'b0);
			it.hz = draw_width(1'b0);
			if (n < 240) begin
				it.key = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
				if (pick < 30) it.action = ACT_SET;
				else if (pick < 60) it.action = ACT_INC;
				else if (pick < 92) it.action = ACT_GET;
				else it.action = ACT_SPARE;
				// Most sets store widths; the rest may carry a negative one.
				if (it.action == ACT_SET && pick % 4 != 0) begin
					it.hx = draw_width(1'b1);
					it.hy = draw_width(1'b1);
					it.hz = draw_width(1'b1);
				end
			end else if (n < 560 || pick < 25) begin
				if (n < 560 && pick >= 85) begin
					it.action = ACT_W'($urandom_range(0, 3));
					it.key    = any_seen_key();
				end else begin
					it.action = ACT_SET;
					it.key    = fresh_key();
					it.hx     = draw_width(1'b1);
					it.hy     = draw_width(1'b1);
					it.hz     = draw_width(1'b1);
					seen_keys.push_back(it.key);
				end
			end else begin
				it.key = any_seen_key();
				if (pick < 55) begin
					// Dropping a known key: force one width negative.
					it.action = ACT_SET;
					case ($urandom_range(0, 2))
						0: it.hx[WIDTH_W-1] = 1'b1;
						1: it.hy[WIDTH_W-1] = 1'b1;
						default: it.hz[WIDTH_W-1] = 1'b1;
					endcase
				end else if (pick < 80) begin
					it.action = ACT_INC;
				end else begin
					it.action = ACT_GET;
				end
			end
			send_item(it);
			pending_widths.push_back(table_apply(it));
		end
		req_ch.valid <= 1'b0;

		while (pending_widths.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tagged_halo_width_table_core_test: clean");
		end else begin
			$display("tagged_halo_width_table_core_test: errors");
		end
		$finish;
	end

endmodule

FILE: tagged_halo_width_table_core.f
+incdir+design
design/thwt_pkg.sv
design/thwt_if.sv
design/tagged_halo_width_table_core.sv
design/thwt_checker.sv
dv/tagged_halo_width_table_core_test.sv
